// ===== src/hill_cipher_block_core_assert.svh =====
// ----------------------------------------------------------------------------
// Hill cipher block core assertion macros
// Clocked on clk; the first two implication forms are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef HILL_CIPHER_BLOCK_CORE_ASSERT_SVH
`define HILL_CIPHER_BLOCK_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define HCB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define HCB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define HCB_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/hcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Hill cipher block package
// Sizes and the stage payload type shared by the cell row and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcb_pkg;

  localparam int BLOCK_BYTES = 8;
  localparam int KEY_ROWS    = 8;
  localparam int BYTE_W      = 8;
  localparam int DATA_W      = 64;
  localparam int ROW_IDX_W   = $clog2(KEY_ROWS);
  localparam int CFG_IDX_W   = ROW_IDX_W + 1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [KEY_ROWS-1:0] byte_vec_t;

  typedef struct packed {
    logic [DATA_W-1:0] plain;
    byte_vec_t         acc;
  } stage_t;

endpackage

`default_nettype wire

// ===== src/hill_cipher_block_core.sv =====
// ----------------------------------------------------------------------------
// Hill cipher block core (matrix product modulo 256)
// One column cell per block byte; each cell holds one block and passes it on.
// Throughput: one block per cycle unless the output stalls.
// A stalled output holds the last cell; earlier cells fill only while empty.
// Reset: synchronous; clears all cell valid flags and the key rows to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hill_cipher_block_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          wr_en,
  input  wire logic [hcb_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [hcb_pkg::DATA_W-1:0]    wr_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [hcb_pkg::DATA_W-1:0]    s_axis_tdata,  // [63:0] plain_block
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [hcb_pkg::DATA_W-1:0]         m_axis_tdata   // [63:0] cipher_block
);
  import hcb_pkg::*;

  logic [DATA_W-1:0]    key_row [KEY_ROWS];
  byte_vec_t            key_col [BLOCK_BYTES];
  stage_t               link_stage [BLOCK_BYTES+1];
  logic [BLOCK_BYTES:0] link_vld;
  logic [BLOCK_BYTES:0] link_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        key_row[r] <= '0;
      end
    end else if (wr_en && (wr_index < CFG_IDX_W'(KEY_ROWS))) begin
      key_row[wr_index[ROW_IDX_W-1:0]] <= wr_data;
    end
  end

  always_comb begin
    for (int c = 0; c < BLOCK_BYTES; c++) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        key_col[c][r] = (r < BLOCK_BYTES) ? key_row[r][BYTE_W*c +: BYTE_W] : '0;
      end
    end
  end

  assign link_vld[0]         = s_axis_tvalid;
  assign link_stage[0].plain = s_axis_tdata;
  assign link_stage[0].acc   = '0;
  assign s_axis_tready       = link_ready[0];

  for (genvar j = 0; j < BLOCK_BYTES; j++) begin : g_cell
    hcb_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_vld    (link_vld[j]),
      .in_ready  (link_ready[j]),
      .in_stage  (link_stage[j]),
      .in_byte   (link_stage[j].plain[BYTE_W*j +: BYTE_W]),
      .key_col   (key_col[j]),
      .out_vld   (link_vld[j+1]),
      .out_ready (link_ready[j+1]),
      .out_stage (link_stage[j+1])
    );
  end

  assign link_ready[BLOCK_BYTES] = m_axis_tready;
  assign m_axis_tvalid           = link_vld[BLOCK_BYTES];
  assign m_axis_tdata            = DATA_W'(link_stage[BLOCK_BYTES].acc);

endmodule

`default_nettype wire

// ===== src/hcb_cell.sv =====
// ----------------------------------------------------------------------------
// Hill cipher column cell
// Adds one key column times one plaintext byte into the running row sums,
// registers the result and hands it to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcb_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_vld,
  output logic                   in_ready,
  input  wire hcb_pkg::stage_t   in_stage,
  input  wire hcb_pkg::byte_t    in_byte,
  input  wire hcb_pkg::byte_vec_t key_col,
  output logic                   out_vld,
  input  wire logic              out_ready,
  output hcb_pkg::stage_t        out_stage
);
  import hcb_pkg::*;

  byte_t               prod [KEY_ROWS];
  stage_t              stage_next;
  logic                vld;
  stage_t              stage;

  always_comb begin
    stage_next.plain = in_stage.plain;
    for (int r = 0; r < KEY_ROWS; r++) begin
      prod[r]             = key_col[r] * in_byte;
      stage_next.acc[r]   = in_stage.acc[r] + prod[r];
    end
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_vld) begin
      stage <= stage_next;
    end
  end

  assign out_vld   = vld;
  assign out_stage = stage;

endmodule

`default_nettype wire

// ===== src/hcb_checker.sv =====
// ----------------------------------------------------------------------------
// Hill cipher block core checker
// Port-level checks of reset, output hold and input availability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hill_cipher_block_core_assert.svh"

module hcb_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [hcb_pkg::DATA_W-1:0]    m_axis_tdata
);
  import hcb_pkg::*;

  `HCB_ASSERT_RST(a_rst_clears_out, rst, !m_axis_tvalid)
  `HCB_ASSERT_IMP(a_free_out_opens_in, !m_axis_tvalid || m_axis_tready, s_axis_tready)
  `HCB_ASSERT_NXT(a_stall_holds_vld, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `HCB_ASSERT_NXT(a_stall_holds_data, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind hill_cipher_block_core hcb_checker u_hcb_checker (.*);

`default_nettype wire

// ===== verif/tb_hill_cipher_block_core.sv =====
// ----------------------------------------------------------------------------
// Hill cipher block core testbench
// Loads key matrices through the register port and streams plaintext blocks
// with random gaps on both sides except in one phase. Each accepted block is
// turned into its ciphertext by a matrix product modulo 256 in the bench, and
// every output transaction is compared in order against those predictions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hill_cipher_block_core;

  import hcb_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 9;
  localparam int IDLE_PERCENT    = 19;
  localparam int SETTLE_CYCLES   = BLOCK_BYTES + 4;
  localparam int RANDOM_PHASES   = 5;
  localparam int BLOCKS_PER_PHASE = 220;
  localparam int REG_KEY_ROW_BASE = 0;
  localparam int REG_INDEX_LIMIT  = REG_KEY_ROW_BASE + KEY_ROWS;
  localparam int REG_INDEX_SPAN   = 1 << CFG_IDX_W;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [DATA_W-1:0]    wr_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;

  logic [DATA_W-1:0] key_shadow [KEY_ROWS];
  logic [DATA_W-1:0] cipher_expected [$];
  bit                stall_en = 1'b1;
  int                err_count = 0;
  int                blocks_sent = 0;
  int                blocks_checked = 0;
  int                key_loads = 0;

  hill_cipher_block_core u_top (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [63:0] plain_block
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // [63:0] cipher_block
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [DATA_W-1:0] hill_encrypt(input logic [DATA_W-1:0] plain);
    logic [DATA_W-1:0] cipher;
    byte_t             acc;
    logic [15:0]       prod;
    cipher = '0;
    for (int r = 0; r < BLOCK_BYTES && r < KEY_ROWS; r++) begin
      acc = '0;
      for (int c = 0; c < BLOCK_BYTES; c++) begin
        prod = key_shadow[r][8*c +: 8] * plain[8*c +: 8];
        acc  = acc + prod[7:0];
      end
      cipher[8*r +: 8] = acc;
    end
    return cipher;
  endfunction

  // Either fully random bits or random bytes mostly replaced by corner values.
  function automatic logic [DATA_W-1:0] rand_word(input bit corners);
    logic [DATA_W-1:0] w;
    byte_t             pick [4];
    pick[0] = 8'h00;
    pick[1] = 8'hFF;
    pick[2] = 8'h80;
    pick[3] = 8'h01;
    w = {$urandom, $urandom};
    if (corners) begin
      for (int b = 0; b < 8; b++) begin
        if ($urandom_range(3) != 0) w[8*b +: 8] = pick[$urandom_range(3)];
      end
    end
    return w;
  endfunction

  // Register model and scoreboard share one process so order is fixed.
  always @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < KEY_ROWS; r++) key_shadow[r] = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cipher_expected.size() == 0) begin
          $display("%0t: unexpected cipher block %h", $time, m_axis_tdata);
          err_count++;
        end else begin
          if (m_axis_tdata !== cipher_expected[0]) begin
            $display("%0t: cipher_block mismatch expected %h actual %h",
                     $time, cipher_expected[0], m_axis_tdata);
            err_count++;
          end
          void'(cipher_expected.pop_front());
          blocks_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        cipher_expected.push_back(hill_encrypt(s_axis_tdata));
      end
      if (wr_en && wr_index < REG_INDEX_LIMIT) begin
        key_shadow[wr_index - REG_KEY_ROW_BASE] = wr_data;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !stall_en || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  task automatic send_block(input logic [DATA_W-1:0] plain);
    while (stall_en && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= plain;
    do @(posedge clk); while (!s_axis_tready);
    blocks_sent++;
  endtask

  task automatic drain_blocks();
    s_axis_tvalid <= 1'b0;
    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value, input bit last);
    wr_en    <= 1'b1;
    wr_index <= CFG_IDX_W'(idx);
    wr_data  <= value;
    @(posedge clk);
    if (last) wr_en <= 1'b0;
  endtask

  task automatic load_key(input logic [DATA_W-1:0] rows [KEY_ROWS]);
    for (int r = 0; r < KEY_ROWS; r++) begin
      write_reg(REG_KEY_ROW_BASE + r, rows[r], r == KEY_ROWS - 1);
    end
    key_loads++;
  endtask

  task automatic test_reset_key();
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89AB_CDEF);
    drain_blocks();
  endtask

  task automatic test_identity_key();
    logic [DATA_W-1:0] rows [KEY_ROWS];
    for (int r = 0; r < KEY_ROWS; r++) rows[r] = DATA_W'(1) << (8 * r);
    load_key(rows);
    send_block('0);
    send_block('1);
    send_block({8{8'h80}});
    send_block({8{8'h01}});
    send_block(64'hFEDC_BA98_7654_3210);
    send_block(64'h00FF_00FF_FF00_FF00);
    drain_blocks();
  endtask

  task automatic test_full_key();
    logic [DATA_W-1:0] rows [KEY_ROWS];
    for (int r = 0; r < KEY_ROWS; r++) rows[r] = '1;
    load_key(rows);
    send_block('1);
    send_block({8{8'h80}});
    send_block(64'h0102_0408_1020_4080);
    drain_blocks();
  endtask

  // Writes above the last key row must leave the key untouched.
  task automatic test_unmapped_index();
    logic [DATA_W-1:0] rows [KEY_ROWS];
    for (int r = 0; r < KEY_ROWS; r++) rows[r] = rand_word(1'b0);
    load_key(rows);
    for (int idx = REG_INDEX_LIMIT; idx < REG_INDEX_SPAN; idx++) begin
      write_reg(idx, rand_word(1'b0), idx == REG_INDEX_SPAN - 1);
    end
    send_block('1);
    send_block(rand_word(1'b0));
    send_block(rand_word(1'b1));
    send_block(64'h8040_2010_0804_0201);
    drain_blocks();
  endtask

  task automatic test_random_keys();
    logic [DATA_W-1:0] rows [KEY_ROWS];
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      stall_en = (p != 2);
      for (int r = 0; r < KEY_ROWS; r++) rows[r] = rand_word(p == 1);
      load_key(rows);
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        send_block(rand_word($urandom_range(3) == 0));
      end
      drain_blocks();
    end
    stall_en = 1'b1;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_key();
    test_identity_key();
    test_full_key();
    test_unmapped_index();
    test_random_keys();
    if (cipher_expected.size() != 0) begin
      $display("%0t: %0d cipher blocks never arrived", $time, cipher_expected.size());
      err_count++;
    end
    $display("Covered %0d plaintext blocks under %0d key matrices, %0d outputs checked",
             blocks_sent, key_loads, blocks_checked);
    $display("Included zero, identity, all-ones and random keys plus unmapped writes");
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
